// ----- rtl/rclrx_pkg.sv -----
// Package with shared types and constants of the radio-control link receiver.
`default_nettype none
package rclrx_pkg;
   localparam int HOP_TRIES_DEF    = 4;
   localparam int PACKET_BYTES_DEF = 15;

   localparam logic [7:0] HDR_CTRL      = 8'd165;
   localparam logic [7:0] HDR_BIND      = 8'ha4;
   localparam logic [7:0] HDR_BIND_TLM  = 8'ha3;
   localparam logic [7:0] EXPERT_CODE   = 8'hfa;
   localparam logic [31:0] HOP_GUARD_US = 32'd1000;

   localparam logic [1:0] EV_NONE   = 2'd0;
   localparam logic [1:0] EV_BIND   = 2'd1;
   localparam logic [1:0] EV_VALID  = 2'd2;
   localparam logic [1:0] EV_REJECT = 2'd3;

   localparam logic [1:0] ACT_NONE  = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_FLUSH = 2'd2;

   localparam logic [1:0] REG_PKT_PERIOD = 2'd0;
   localparam logic [1:0] REG_TLM_PERIOD = 2'd1;
   localparam logic [1:0] REG_FAILSAFE   = 2'd2;
   localparam logic [1:0] REG_TLM_TMO    = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_TIMING,
      ST_MUL,
      ST_DIV,
      ST_FINISH,
      ST_OUT
   } state_type;
endpackage
`default_nettype wire

// ----- rtl/rc_link_receiver_hop_failsafe_top.sv -----
// Radio-control link receiver: packet decode, hopping, telemetry and failsafe.
// Every item runs the sum, timing, multiply, divide, finish and output states; a final
// byte in normal mode takes 14 checksum steps, then a 32-step shift-subtract divider for the hop test.
// Throughput: one item at a time; the next item is taken once the result is taken.
// Reset (synchronous, active high) clears all control state and restores the
// register defaults; the packet store and hop table are undefined until written.
`default_nettype none
module rc_link_receiver_hop_failsafe_top #(
   parameter int HOP_TRIES = rclrx_pkg::HOP_TRIES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_command,
   input  wire logic [7:0]  req_payload_byte,
   input  wire logic        req_byte_last,
   input  wire logic [31:0] req_now_us,
   input  wire logic        req_tx_done,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_event_res,
   output logic [9:0]       rsp_roll_raw,
   output logic [9:0]       rsp_pitch_raw,
   output logic [9:0]       rsp_yaw_raw,
   output logic [9:0]       rsp_throttle_raw,
   output logic [8:0]       rsp_switch_flags,
   output logic [7:0]       rsp_radio_channel,
   output logic [39:0]      rsp_bound_address,
   output logic [1:0]       rsp_telemetry_action,
   output logic             rsp_failsafe,
   output logic             rsp_link_ready,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   import rclrx_pkg::*;

   localparam int NB = PACKET_BYTES_DEF;
   localparam int SW = $clog2(HOP_TRIES + 2);
   localparam logic [SW-1:0] SKIP_MAX = SW'(HOP_TRIES + 1);
   localparam logic [31:0] TRIES32 = 32'(HOP_TRIES);

   // State machine and item latch.
   state_type state_ff, state_in;
   logic        dec_ff, txd_ff;
   logic [31:0] now_ff;

   // Configuration registers.
   logic [15:0] pkt_per_ff, tlm_per_ff, tlm_tmo_ff;
   logic [31:0] fs_time_ff;

   // Link state.
   logic [7:0]  store_ff [NB];
   logic [7:0]  hop_tab_ff [4];
   logic [3:0]  bcnt_ff;
   logic        mode_ff, tlm_on_ff, busy_ff, tfail_ff, fs_ff;
   logic [39:0] addr_ff;
   logic [1:0]  hop_ff, lgh_ff;
   logic [31:0] lrx_ff, lgood_ff, sst_ff;
   logic [SW-1:0] skip_ff;
   logic [3:0]  good_ff;

   // Shared iterative datapath: checksum index, divider.
   logic [3:0]  cnt_ff;
   logic [5:0]  dcnt_ff;
   logic [7:0]  sum_ff;
   logic [31:0] per_ff, quo_ff, rem_ff, elap_ff;
   logic [31:0] lim_ff;

   // Result register.
   logic [1:0]  ev_ff, act_ff;
   logic [9:0]  roll_ff, pitch_ff, yaw_ff, thr_ff;
   logic [8:0]  sw_ff;

   logic req_take, csr_take;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = (state_ff == ST_IDLE);
   assign csr_take  = csr_valid && csr_ready;
   assign rsp_valid = (state_ff == ST_OUT);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_take) state_in = ST_SUM;
         ST_SUM:    if (!dec_ff || cnt_ff == 4'(NB - 2))
                       state_in = ST_TIMING;
         ST_TIMING: state_in = ST_MUL;
         ST_MUL:    state_in = ST_DIV;
         ST_DIV:    if (dcnt_ff == 6'd31) state_in = ST_FINISH;
         ST_FINISH: state_in = ST_OUT;
         ST_OUT:    if (!rsp_stall) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         pkt_per_ff <= 16'd3000;
         tlm_per_ff <= 16'd5000;
         fs_time_ff <= 32'd1000000;
         tlm_tmo_ff <= 16'd10000;
      end else if (csr_take) begin
         case (csr_index)
            REG_PKT_PERIOD: pkt_per_ff <= csr_data[15:0];
            REG_TLM_PERIOD: tlm_per_ff <= csr_data[15:0];
            REG_FAILSAFE:   fs_time_ff <= csr_data;
            REG_TLM_TMO:    tlm_tmo_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // Decoded view of the current store for the final byte.
   logic [7:0] s [NB];
   always_comb begin
      for (int i = 0; i < NB; i++) s[i] = store_ff[i];
      if (bcnt_ff < 4'(NB)) s[bcnt_ff] = req_payload_byte;
   end

   logic [31:0] per_sel;
   logic [15:0] per16;
   always_comb begin
      per16 = tlm_on_ff ? tlm_per_ff : pkt_per_ff;
      if (per16 == 16'd0) per16 = 16'd1;
      per_sel = {16'd0, per16};
   end

   logic [32:0] dsub;
   assign dsub = {rem_ff, quo_ff[31]} - {1'b0, per_ff};

   logic [1:0] hop_inc;
   assign hop_inc = hop_ff + 2'd1;

   // Main datapath and link state.
   always_ff @(posedge clock) begin
      if (reset) begin
         bcnt_ff <= '0; mode_ff <= 1'b0; tlm_on_ff <= 1'b0; addr_ff <= '0;
         hop_ff <= '0; lgh_ff <= '0; lrx_ff <= '0; lgood_ff <= '0;
         skip_ff <= '0; tfail_ff <= 1'b0; fs_ff <= 1'b0; busy_ff <= 1'b0;
         sst_ff <= '0; good_ff <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: if (req_take) begin
               // A final byte seen in normal mode is a control packet to check.
               dec_ff <= req_command && req_byte_last && mode_ff;
               txd_ff <= req_tx_done; now_ff <= req_now_us;
               ev_ff <= EV_NONE; act_ff <= ACT_NONE;
               roll_ff <= '0; pitch_ff <= '0; yaw_ff <= '0; thr_ff <= '0;
               sw_ff <= '0; cnt_ff <= '0; sum_ff <= '0;
               if (req_command) begin
                  if (bcnt_ff < 4'(NB)) begin
                     store_ff[bcnt_ff] <= req_payload_byte;
                     bcnt_ff <= bcnt_ff + 4'd1;
                  end
                  if (req_byte_last) begin
                     bcnt_ff <= '0;
                     if (!mode_ff) begin
                        if (s[0] == HDR_BIND || s[0] == HDR_BIND_TLM) begin
                           if (s[0] == HDR_BIND_TLM) tlm_on_ff <= 1'b1;
                           for (int i = 0; i < 4; i++) hop_tab_ff[i] <= s[6+i];
                           addr_ff <= {s[1], s[2], s[3], s[4], s[5]};
                           mode_ff <= 1'b1;
                           ev_ff <= EV_BIND;
                        end else ev_ff <= EV_REJECT;
                     end
                  end
               end
            end
            ST_SUM: if (dec_ff) begin
               sum_ff <= sum_ff + store_ff[cnt_ff];
               cnt_ff <= cnt_ff + 4'd1;
            end
            ST_TIMING: begin
               // Packet decision, telemetry and timing loss.
               logic busy_v, just_v, tf_v;
               logic [1:0] hop_v, act_v;
               logic [31:0] lrx_v;
               busy_v = busy_ff; just_v = 1'b0; hop_v = hop_ff; act_v = act_ff;
               lrx_v = lrx_ff; tf_v = tfail_ff;
               if (dec_ff) begin
                  if (store_ff[0] == HDR_CTRL && sum_ff == store_ff[NB-1]) begin
                     ev_ff <= EV_VALID;
                     roll_ff  <= {store_ff[4][1:0], store_ff[5]};
                     pitch_ff <= {store_ff[6][1:0], store_ff[7]};
                     thr_ff   <= {store_ff[8][1:0], store_ff[9]};
                     yaw_ff   <= {store_ff[10][1:0], store_ff[11]};
                     sw_ff <= {store_ff[3][7], store_ff[2][4], store_ff[2][5],
                               store_ff[3][5], store_ff[3][2], store_ff[2][3],
                               store_ff[1] == EXPERT_CODE, store_ff[2][1],
                               store_ff[2][0]};
                     if (tlm_on_ff) begin
                        if (!busy_v) begin
                           busy_v = 1'b1; sst_ff <= now_ff; act_v = ACT_START;
                           just_v = 1'b1;
                        end else if (txd_ff) begin
                           busy_v = 1'b0; hop_v = hop_v + 2'd1; act_v = ACT_FLUSH;
                        end else if (now_ff - sst_ff > {16'd0, tlm_tmo_ff}) begin
                           busy_v = 1'b0; act_v = ACT_FLUSH;
                        end
                     end
                     skip_ff <= '0; tf_v = 1'b0; lgh_ff <= hop_v;
                     lrx_v = now_ff; lgood_ff <= now_ff; fs_ff <= 1'b0;
                     if (!busy_v) hop_v = hop_v + 2'd1;
                  end else ev_ff <= EV_REJECT;
                  if (good_ff < 4'd10) good_ff <= good_ff + 4'd1;
               end
               if (busy_v && !just_v) begin
                  if (txd_ff) begin
                     busy_v = 1'b0; hop_v = hop_v + 2'd1; act_v = ACT_FLUSH;
                  end else if (now_ff - sst_ff > {16'd0, tlm_tmo_ff}) begin
                     busy_v = 1'b0; act_v = ACT_FLUSH;
                  end
               end
               busy_ff <= busy_v; hop_ff <= hop_v; act_ff <= act_v;
               lrx_ff <= lrx_v; tfail_ff <= tf_v;
               per_ff <= per_sel;
            end
            ST_MUL: begin
               // Lost-timing hop; threshold = tries * period + guard.
               lim_ff <= TRIES32 * per_ff + HOP_GUARD_US;
               elap_ff <= now_ff - lrx_ff;
               dcnt_ff <= '0;
            end
            ST_DIV: begin
               if (dcnt_ff == 6'd0) begin
                  if (mode_ff && (now_ff - lrx_ff) > lim_ff) begin
                     lrx_ff <= now_ff;
                     hop_ff <= (tfail_ff ? hop_ff : lgh_ff) + 2'd1;
                     tfail_ff <= 1'b1;
                     quo_ff <= '0;
                     elap_ff <= '0;
                  end else quo_ff <= now_ff - lrx_ff;
                  rem_ff <= '0;
               end else begin
                  if (!dsub[32]) begin
                     rem_ff <= dsub[31:0];
                     quo_ff <= {quo_ff[30:0], 1'b1};
                  end else begin
                     rem_ff <= {rem_ff[30:0], quo_ff[31]};
                     quo_ff <= {quo_ff[30:0], 1'b0};
                  end
               end
               dcnt_ff <= dcnt_ff + 6'd1;
            end
            ST_FINISH: begin
               // Last quotient bit, then skip test and failsafe.
               logic [31:0] q;
               q = dsub[32] ? {quo_ff[30:0], 1'b0} : {quo_ff[30:0], 1'b1};
               if (mode_ff && !tfail_ff && !busy_ff && skip_ff < SKIP_MAX) begin
                  if (elap_ff > HOP_GUARD_US && q >= 32'(skip_ff) + 32'd1) begin
                     hop_ff <= hop_inc;
                     skip_ff <= skip_ff + SW'(1);
                  end
               end
               if (now_ff - lgood_ff > fs_time_ff) fs_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign rsp_event_res        = ev_ff;
   assign rsp_roll_raw         = roll_ff;
   assign rsp_pitch_raw        = pitch_ff;
   assign rsp_yaw_raw          = yaw_ff;
   assign rsp_throttle_raw     = thr_ff;
   assign rsp_switch_flags     = sw_ff;
   assign rsp_radio_channel    = mode_ff ? hop_tab_ff[hop_ff] : 8'd0;
   assign rsp_bound_address    = addr_ff;
   assign rsp_telemetry_action = act_ff;
   assign rsp_failsafe         = fs_ff;
   assign rsp_link_ready       = (good_ff >= 4'd10);

   // Checks.
   a_busy_only_tlm: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> tlm_on_ff) else $error("beacon busy without telemetry");
   a_stall_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> req_stall) else $error("accepting during work");
   a_skip_cap: assert property (@(posedge clock) disable iff (reset)
      skip_ff <= SKIP_MAX) else $error("skip count past limit");
   a_good_cap: assert property (@(posedge clock) disable iff (reset)
      good_ff <= 4'd10) else $error("frame count past limit");
endmodule
`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for the radio-control link receiver with hopping and failsafe.
`timescale 1ns / 100ps
`default_nettype none
module tb;
   import rclrx_pkg::*;

   // Expected contents of one result item.
   typedef struct {
      logic [1:0]  event_res;
      logic [9:0]  roll;
      logic [9:0]  pitch;
      logic [9:0]  yaw;
      logic [9:0]  throttle;
      logic [8:0]  switches;
      logic [7:0]  channel;
      logic [39:0] address;
      logic [1:0]  action;
      logic        failsafe;
      logic        link_ready;
   } link_result_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_command;
   logic [7:0]  req_payload_byte;
   logic        req_byte_last;
   logic [31:0] req_now_us;
   logic        req_tx_done;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_event_res;
   logic [9:0]  rsp_roll_raw;
   logic [9:0]  rsp_pitch_raw;
   logic [9:0]  rsp_yaw_raw;
   logic [9:0]  rsp_throttle_raw;
   logic [8:0]  rsp_switch_flags;
   logic [7:0]  rsp_radio_channel;
   logic [39:0] rsp_bound_address;
   logic [1:0]  rsp_telemetry_action;
   logic        rsp_failsafe;
   logic        rsp_link_ready;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;

   rc_link_receiver_hop_failsafe_top i_dut (.*);

   // Shadow of the block's state and registers.
   logic [15:0] cfg_pkt_period;
   logic [15:0] cfg_tlm_period;
   logic [31:0] cfg_failsafe;
   logic [15:0] cfg_tlm_timeout;
   logic [7:0]  rx_store [15];
   logic [3:0]  rx_count;
   logic        normal_mode;
   logic        tlm_on;
   logic [7:0]  hop_tab [4];
   logic [39:0] addr_shadow;
   logic [1:0]  hop_idx;
   logic [1:0]  good_hop;
   logic [31:0] rx_time;
   logic [31:0] good_time;
   logic [2:0]  skips;
   logic        lost_timing;
   logic        fs_flag;
   logic        beacon;
   logic [31:0] beacon_t0;
   logic [3:0]  frames;

   link_result_type expected_q [$];
   int          errors;
   int          items_sent;
   int          idle_pct;
   int          stall_pct;
   int          quiet_cycles;
   logic [31:0] now_t;

   // Clock generation.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Compute the result of one accepted item and advance the shadow state.
   function automatic link_result_type link_predict(logic cmd, logic [7:0] b, logic last,
                                                    logic [31:0] now, logic txd);
      link_result_type r;
      logic         started;
      logic [7:0]   sum;
      logic [31:0]  period;
      logic [31:0]  elapsed;
      r = '{default: '0};
      started = 1'b0;
      if (cmd) begin
         if (rx_count < 15) begin
            rx_store[rx_count] = b;
            rx_count++;
         end
         if (last) begin
            rx_count = 0;
            if (!normal_mode) begin
               if (rx_store[0] == HDR_BIND || rx_store[0] == HDR_BIND_TLM) begin
                  if (rx_store[0] == HDR_BIND_TLM) tlm_on = 1'b1;
                  for (int i = 0; i < 4; i++) hop_tab[i] = rx_store[6 + i];
                  addr_shadow = {rx_store[1], rx_store[2], rx_store[3], rx_store[4],
                                 rx_store[5]};
                  normal_mode = 1'b1;
                  r.event_res = EV_BIND;
               end else begin
                  r.event_res = EV_REJECT;
               end
            end else begin
               sum = '0;
               for (int i = 0; i < 14; i++) sum += rx_store[i];
               if (rx_store[0] == HDR_CTRL && sum == rx_store[14]) begin
                  r.event_res = EV_VALID;
                  r.roll = {rx_store[4][1:0], rx_store[5]};
                  r.pitch = {rx_store[6][1:0], rx_store[7]};
                  r.throttle = {rx_store[8][1:0], rx_store[9]};
                  r.yaw = {rx_store[10][1:0], rx_store[11]};
                  r.switches = {rx_store[3][7], rx_store[2][4], rx_store[2][5],
                                rx_store[3][5], rx_store[3][2], rx_store[2][3],
                                rx_store[1] == EXPERT_CODE, rx_store[2][1], rx_store[2][0]};
                  if (tlm_on) begin
                     if (!beacon) begin
                        beacon = 1'b1;
                        beacon_t0 = now;
                        r.action = ACT_START;
                        started = 1'b1;
                     end else if (txd) begin
                        beacon = 1'b0;
                        hop_idx++;
                        r.action = ACT_FLUSH;
                     end else if (now - beacon_t0 > 32'(cfg_tlm_timeout)) begin
                        beacon = 1'b0;
                        r.action = ACT_FLUSH;
                     end
                  end
                  skips = 0;
                  lost_timing = 1'b0;
                  good_hop = hop_idx;
                  rx_time = now;
                  good_time = now;
                  fs_flag = 1'b0;
                  if (!beacon) hop_idx++;
               end else begin
                  r.event_res = EV_REJECT;
               end
               if (frames < 10) frames++;
            end
         end
      end

      // Beacon end by completion or by timeout.
      if (beacon && !started) begin
         if (txd) begin
            beacon = 1'b0;
            hop_idx++;
            r.action = ACT_FLUSH;
         end else if (now - beacon_t0 > 32'(cfg_tlm_timeout)) begin
            beacon = 1'b0;
            r.action = ACT_FLUSH;
         end
      end

      period = tlm_on ? 32'(cfg_tlm_period) : 32'(cfg_pkt_period);
      if (period == 0) period = 1;

      // Long silence: fall back to the last good channel and step on.
      if (normal_mode && now - rx_time > HOP_TRIES_DEF * period + HOP_GUARD_US) begin
         rx_time = now;
         if (!lost_timing) hop_idx = good_hop;
         hop_idx++;
         lost_timing = 1'b1;
      end

      // Missed packet: hop once per elapsed period, up to HOP_TRIES + 1 hops.
      if (normal_mode && !lost_timing && !beacon && skips < HOP_TRIES_DEF + 1) begin
         elapsed = now - rx_time;
         if (elapsed > HOP_GUARD_US && elapsed / period >= 32'(skips) + 1) begin
            hop_idx++;
            skips++;
         end
      end

      if (now - good_time > cfg_failsafe) fs_flag = 1'b1;

      r.channel = normal_mode ? hop_tab[hop_idx] : 8'd0;
      r.address = addr_shadow;
      r.failsafe = fs_flag;
      r.link_ready = frames >= 10;
      return r;
   endfunction

   // Send one item, with random idle cycles ahead of it.
   task automatic send_item(logic cmd, logic [7:0] b, logic last, logic txd);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_payload_byte <= b;
      req_byte_last <= last;
      req_now_us <= now_t;
      req_tx_done <= txd;
      do @(posedge clock); while (req_stall);
      expected_q.push_back(link_predict(cmd, b, last, now_t, txd));
      items_sent++;
      @(negedge clock);
   endtask

   // Send a packet of bytes with a short time step between bytes.
   task automatic send_packet(logic [7:0] bytes [$]);
      for (int i = 0; i < bytes.size(); i++) begin
         now_t += $urandom_range(0, 40);
         send_item(1'b1, bytes[i], i == bytes.size() - 1, $urandom_range(0, 3) == 0);
      end
   endtask

   // Wait until every expected item has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
   endtask

   // Write one register while the block is idle.
   task automatic write_register(logic [1:0] index, logic [31:0] value);
      drain_results();
      repeat (60) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         REG_PKT_PERIOD: cfg_pkt_period = value[15:0];
         REG_TLM_PERIOD: cfg_tlm_period = value[15:0];
         REG_FAILSAFE:   cfg_failsafe = value;
         default:        cfg_tlm_timeout = value[15:0];
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Build a well-formed control packet with random, often extreme, content.
   function automatic void build_control(ref logic [7:0] bytes [$]);
      logic [7:0] sum;
      bytes.delete();
      bytes.push_back(HDR_CTRL);
      for (int i = 1; i < 14; i++) begin
         case ($urandom_range(0, 7))
            0:       bytes.push_back(8'h00);
            1:       bytes.push_back(8'hff);
            default: bytes.push_back(8'($urandom));
         endcase
      end
      if ($urandom_range(0, 3) == 0) bytes[1] = EXPERT_CODE;
      sum = '0;
      foreach (bytes[i]) sum += bytes[i];
      bytes.push_back(sum);
   endfunction

   // Time step between packets, mostly near the expected spacing.
   function automatic logic [31:0] packet_gap();
      logic [31:0] period;
      period = tlm_on ? 32'(cfg_tlm_period) : 32'(cfg_pkt_period);
      case ($urandom_range(0, 19))
         0:       return $urandom;
         1, 2:    return $urandom_range(0, 1500);
         3, 4, 5: return period * $urandom_range(2, 6) + $urandom_range(0, 2000);
         default: return period + $urandom_range(0, 400) - 200;
      endcase
   endfunction

   // Directed part: fill the store, bind-mode cases, bind, then control extremes.
   task automatic test_bind_and_extremes();
      logic [7:0] bytes [$];
      bytes.delete();
      bytes.push_back(8'h11);
      for (int i = 1; i < 15; i++) bytes.push_back(8'($urandom));
      send_packet(bytes);
      now_t += 100;
      send_item(1'b0, 8'hff, 1'b1, 1'b1);
      bytes = '{($urandom_range(0, 1) != 0) ? HDR_BIND_TLM : HDR_BIND};
      send_packet(bytes);
      // All-ones content with one byte too many; the extra byte is dropped.
      bytes.delete();
      bytes.push_back(HDR_CTRL);
      for (int i = 1; i < 14; i++) bytes.push_back(8'hff);
      bytes.push_back(8'(8'd165 + 13 * 8'hff));
      bytes.push_back(8'h00);
      now_t += packet_gap();
      send_packet(bytes);
      // Wrong checksum, then a wrong header.
      build_control(bytes);
      bytes[14] = ~bytes[14];
      now_t += packet_gap();
      send_packet(bytes);
      bytes = '{8'h00};
      send_packet(bytes);
   endtask

   // Random part: mostly good packets with noise, short, long and broken ones.
   task automatic test_random_traffic(int count);
      logic [7:0] bytes [$];
      int         stop_at;
      int         len;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         build_control(bytes);
         case ($urandom_range(0, 19))
            0, 1: bytes[14] ^= 8'(1 << $urandom_range(0, 7));
            2: begin
               len = $urandom_range(1, 14);
               while (bytes.size() > len) void'(bytes.pop_back());
            end
            3: repeat ($urandom_range(1, 3)) bytes.push_back(8'($urandom));
            4: bytes[0] = 8'($urandom);
            5, 6: begin
               bytes.delete();
               repeat ($urandom_range(1, 3)) begin
                  now_t += $urandom_range(0, 3000);
                  send_item(1'b0, 8'($urandom), 1'($urandom), 1'($urandom));
               end
            end
            default: ;
         endcase
         now_t += packet_gap();
         if (bytes.size() != 0) send_packet(bytes);
      end
   endtask

   // Run the traffic under several register settings and idle patterns.
   task automatic test_settings_and_idling();
      write_register(REG_PKT_PERIOD, 32'd1);
      write_register(REG_TLM_PERIOD, 32'd65535);
      write_register(REG_FAILSAFE, 32'd1);
      write_register(REG_TLM_TMO, 32'd1);
      idle_pct = 75;
      stall_pct = 0;
      test_random_traffic(400);
      write_register(REG_PKT_PERIOD, 32'd65535);
      write_register(REG_TLM_PERIOD, 32'd1);
      write_register(REG_FAILSAFE, 32'hffff_ffff);
      write_register(REG_TLM_TMO, 32'd65535);
      idle_pct = 0;
      stall_pct = 75;
      test_random_traffic(400);
      // A zero period acts as one.
      write_register(REG_PKT_PERIOD, 32'd0);
      write_register(REG_TLM_PERIOD, 32'd0);
      write_register(REG_FAILSAFE, 32'($urandom_range(1000, 200000)));
      write_register(REG_TLM_TMO, 32'($urandom_range(1, 20000)));
      idle_pct = 30;
      stall_pct = 30;
      test_random_traffic(300);
      write_register(REG_PKT_PERIOD, 32'($urandom_range(1000, 6000)));
      write_register(REG_TLM_PERIOD, 32'($urandom_range(1000, 9000)));
      write_register(REG_FAILSAFE, 32'd1000000);
      write_register(REG_TLM_TMO, 32'd10000);
      test_random_traffic(300);
   endtask

   // Response stall pattern, changed at the falling edge.
   always @(negedge clock) begin
      rsp_stall <= reset ? 1'b0 : ($urandom_range(0, 99) < stall_pct);
   end

   // Result checker and watchdog.
   always @(posedge clock) begin
      link_result_type e;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (csr_valid && csr_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= 20000) begin
            $display("timeout: no item accepted for %0d cycles", quiet_cycles);
            $display("DONE: errors detected");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result item at %0t", $realtime);
            end else begin
               e = expected_q.pop_front();
               if (e.event_res !== rsp_event_res || e.roll !== rsp_roll_raw
                   || e.pitch !== rsp_pitch_raw || e.yaw !== rsp_yaw_raw
                   || e.throttle !== rsp_throttle_raw || e.switches !== rsp_switch_flags
                   || e.channel !== rsp_radio_channel || e.address !== rsp_bound_address
                   || e.action !== rsp_telemetry_action || e.failsafe !== rsp_failsafe
                   || e.link_ready !== rsp_link_ready) begin
                  errors++;
                  if (errors <= 10)
                     $display({"mismatch at %0t: exp ev %0d sticks %0d %0d %0d %0d sw %h ",
                               "ch %h addr %h act %0d fs %b rdy %b; got ev %0d sticks ",
                               "%0d %0d %0d %0d sw %h ch %h addr %h act %0d fs %b rdy %b"},
                              $realtime, e.event_res, e.roll, e.pitch, e.yaw, e.throttle,
                              e.switches, e.channel, e.address, e.action, e.failsafe,
                              e.link_ready, rsp_event_res, rsp_roll_raw, rsp_pitch_raw,
                              rsp_yaw_raw, rsp_throttle_raw, rsp_switch_flags,
                              rsp_radio_channel, rsp_bound_address, rsp_telemetry_action,
                              rsp_failsafe, rsp_link_ready);
               end
            end
         end
      end
   end

   // Main sequence.
   initial begin
      errors = 0;
      items_sent = 0;
      quiet_cycles = 0;
      idle_pct = 0;
      stall_pct = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = 1'b0;
      req_payload_byte = '0;
      req_byte_last = 1'b0;
      req_now_us = '0;
      req_tx_done = 1'b0;
      csr_valid = 1'b0;
      csr_index = REG_PKT_PERIOD;
      csr_data = '0;
      cfg_pkt_period = 16'd3000;
      cfg_tlm_period = 16'd5000;
      cfg_failsafe = 32'd1000000;
      cfg_tlm_timeout = 16'd10000;
      rx_count = '0;
      normal_mode = 1'b0;
      tlm_on = 1'b0;
      addr_shadow = '0;
      hop_idx = '0;
      good_hop = '0;
      rx_time = '0;
      good_time = '0;
      skips = '0;
      lost_timing = 1'b0;
      fs_flag = 1'b0;
      beacon = 1'b0;
      beacon_t0 = '0;
      frames = '0;
      now_t = $urandom_range(0, 50000);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_bind_and_extremes();
      test_random_traffic(350);
      // Let everything drain before pushing on.
      drain_results();
      test_settings_and_idling();

      drain_results();
      repeat (100) @(negedge clock);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ----- rc_link_receiver_hop_failsafe_top.f -----
rtl/rclrx_pkg.sv
rtl/rc_link_receiver_hop_failsafe_top.sv
test/tb.sv
